@@ design/msp_pkg.sv @@
// ----------------------------------------------------------------------------
// msp_pkg
// shared types and constants for the mix, saturate and pcm encode block
// ----------------------------------------------------------------------------
package msp_pkg;

    localparam int LEVEL_W           = 20;
    localparam int WORD_W            = 32;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int CFG_IDX_W         = 8;
    localparam int CFG_DATA_W        = 8;
    localparam int BITS_W            = 6;
    localparam int MANT_W            = 23;
    localparam int EXP_W             = 8;
    localparam int FLOAT_BIAS        = 127;
    localparam int IN_TDATA_W        = 40;
    localparam int OUT_TDATA_W       = 40;

    localparam logic [BITS_W-1:0] BITS_8  = BITS_W'(8);
    localparam logic [BITS_W-1:0] BITS_16 = BITS_W'(16);
    localparam logic [BITS_W-1:0] BITS_32 = BITS_W'(32);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_BITS   = 8'd0,
        CFG_FLOAT_FORMAT  = 8'd1,
        CFG_SIGNED_FORMAT = 8'd2,
        CFG_SWAP_BYTES    = 8'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_FLOAT_WIDTH = 2'd1,
        ERR_UNSIGNED_32 = 2'd2,
        ERR_BAD_WIDTH   = 2'd3
    } t_fmt_err;

    typedef struct packed {
        logic [BITS_W-1:0] sample_bits;
        logic              float_format;
        logic              signed_format;
        logic              swap_bytes;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        sample_bits:   BITS_16,
        float_format:  1'b0,
        signed_format: 1'b1,
        swap_bytes:    1'b0
    };

endpackage

@@ design/mix_saturate_pcm_encoder.sv @@
// ----------------------------------------------------------------------------
// mix_saturate_pcm_encoder
// mixes music and effects levels and encodes one pcm sample word per item
// ----------------------------------------------------------------------------
// s_axis carries one item per transfer: music level in tdata[19:0] and
// effects level in tdata[39:20], signed, FRACTION_BITS fraction bits.
// m_axis returns one item per input item, in order: the sample word in
// tdata[31:0], the clip flag in tdata[32] and the format error code in
// tdata[34:33]; upper bits are zero.
// the cfg channel writes one register per transfer (index 0 sample_bits,
// 1 float_format, 2 signed_format, 3 swap_bytes); it is always ready and
// other indices are dropped. write it only while no item is in flight.
// after input acceptance the item passes the input register, then the
// adder, scaler and encoder feeding the result register, where output valid rises.
// throughput is one item per cycle while m_axis is ready. a stall on
// m_axis fills the result register and then the input register, after
// which s_axis_tready drops; nothing is lost or repeated.
// reset clears both valid flags and loads the cfg registers with 16-bit
// signed integer output and no byte swap.
// ----------------------------------------------------------------------------
module mix_saturate_pcm_encoder
    import msp_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // music_level, effects_level
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // sample_word, clipped, format_error
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg                      r_cfg;
    logic                      r_in_valid;
    logic signed [LEVEL_W-1:0] r_music;
    logic signed [LEVEL_W-1:0] r_effects;
    logic                      r_out_valid;
    logic [WORD_W-1:0]         r_word;
    logic                      r_clipped;
    t_fmt_err                  r_error;

    logic                      advance;
    logic [WORD_W-1:0]         n_word;
    logic                      n_clipped;
    t_fmt_err                  n_error;

    assign o_cfg_ready   = 1'b1;
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SAMPLE_BITS:   r_cfg.sample_bits   <= i_cfg_data[BITS_W-1:0];
                CFG_FLOAT_FORMAT:  r_cfg.float_format  <= i_cfg_data[0];
                CFG_SIGNED_FORMAT: r_cfg.signed_format <= i_cfg_data[0];
                CFG_SWAP_BYTES:    r_cfg.swap_bytes    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_music   <= s_axis_tdata[LEVEL_W-1:0];
            r_effects <= s_axis_tdata[2*LEVEL_W-1:LEVEL_W];
        end
    end

    msp_encode #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_encode (
        .i_music   (r_music),
        .i_effects (r_effects),
        .i_cfg     (r_cfg),
        .o_word    (n_word),
        .o_clipped (n_clipped),
        .o_error   (n_error)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_word    <= n_word;
            r_clipped <= n_clipped;
            r_error   <= n_error;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - WORD_W - 3)'(0), r_error, r_clipped, r_word};

endmodule

@@ design/msp_encode.sv @@
// ----------------------------------------------------------------------------
// msp_encode
// adds the two levels and encodes the sum as one float or integer pcm word
// ----------------------------------------------------------------------------
module msp_encode
    import msp_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic signed [LEVEL_W-1:0] i_music,
    input  logic signed [LEVEL_W-1:0] i_effects,
    input  t_cfg                      i_cfg,
    output logic [WORD_W-1:0]         o_word,
    output logic                      o_clipped,
    output t_fmt_err                  o_error
);

    localparam int SUM_W  = LEVEL_W + 1;
    localparam int WIDE_A = SUM_W + WORD_W;
    localparam int WIDE_B = WORD_W + 1 + FRACTION_BITS;
    localparam int WIDE_W = ((WIDE_A > WIDE_B) ? WIDE_A : WIDE_B) + 1;
    localparam int MAG_W  = FRACTION_BITS + 1;
    localparam int POS_W  = $clog2(MAG_W);

    function automatic logic [WORD_W-1:0] swap16(input logic [WORD_W-1:0] w);
        return {16'h0000, w[7:0], w[15:8]};
    endfunction

    function automatic logic [WORD_W-1:0] swap32(input logic [WORD_W-1:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    logic signed [SUM_W-1:0]  sum;
    logic signed [WIDE_W-1:0] s_w;
    logic signed [WIDE_W-1:0] one_w;
    logic signed [WIDE_W-1:0] clamp_w;
    logic                     f_clip;
    logic [MAG_W-1:0]         mag;
    logic [POS_W-1:0]         pos;
    logic [EXP_W-1:0]         expo;
    logic [MAG_W+MANT_W-1:0]  man_w;
    logic [WORD_W-1:0]        f_word;

    logic [4:0]               sh;
    logic [WORD_W-1:0]        mask;
    logic signed [WIDE_W-1:0] p;
    logic signed [WIDE_W-1:0] u;
    logic signed [WIDE_W-1:0] half_w;
    logic signed [WIDE_W-1:0] half_one;
    logic signed [WIDE_W-1:0] maxv_one;
    logic signed [WIDE_W-1:0] top_one;
    logic signed [WIDE_W-1:0] q;
    logic                     i_clip;
    logic [WORD_W-1:0]        i_word;

    assign sum   = SUM_W'(i_music) + SUM_W'(i_effects);
    assign s_w   = WIDE_W'(sum);
    assign one_w = WIDE_W'(1) <<< FRACTION_BITS;

    // float path: clamp to +-1, then normalise
    always_comb begin
        f_clip  = 1'b0;
        clamp_w = s_w;
        if (s_w > one_w) begin
            clamp_w = one_w;
            f_clip  = 1'b1;
        end else if (s_w < -one_w) begin
            clamp_w = -one_w;
            f_clip  = 1'b1;
        end
        mag = clamp_w[WIDE_W-1] ? MAG_W'(-clamp_w) : MAG_W'(clamp_w);
        pos = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (mag[i]) begin
                pos = POS_W'(i);
            end
        end
        expo  = EXP_W'(32'(pos) + (FLOAT_BIAS - FRACTION_BITS));
        man_w = {mag, {MANT_W{1'b0}}} >> pos;
        if (mag == '0) begin
            f_word = '0;
        end else begin
            f_word = {clamp_w[WIDE_W-1], expo, man_w[MANT_W-1:0]};
        end
    end

    // integer path: scale by 2^(b-1)-1, saturate, truncate toward zero
    always_comb begin
        case (i_cfg.sample_bits)
            BITS_8: begin
                sh   = 5'd7;
                mask = 32'h0000_00ff;
            end
            BITS_16: begin
                sh   = 5'd15;
                mask = 32'h0000_ffff;
            end
            BITS_32: begin
                sh   = 5'd31;
                mask = 32'hffff_ffff;
            end
            default: begin
                sh   = 5'd15;
                mask = 32'h0000_ffff;
            end
        endcase
        p        = (s_w <<< sh) - s_w;
        half_w   = WIDE_W'(1) <<< sh;
        half_one = half_w <<< FRACTION_BITS;
        maxv_one = half_one - one_w;
        top_one  = (half_one <<< 1) - one_w;
        u        = p + half_one;
        i_clip   = 1'b0;
        if (i_cfg.signed_format) begin
            if (p > maxv_one) begin
                q      = half_w - WIDE_W'(1);
                i_clip = 1'b1;
            end else if (p < -half_one) begin
                q      = -half_w;
                i_clip = 1'b1;
            end else if (p < 0) begin
                q = -((-p) >>> FRACTION_BITS);
            end else begin
                q = p >>> FRACTION_BITS;
            end
        end else begin
            if (u < 0) begin
                q      = '0;
                i_clip = 1'b1;
            end else if (u > top_one) begin
                q      = (half_w <<< 1) - WIDE_W'(1);
                i_clip = 1'b1;
            end else begin
                q = u >>> FRACTION_BITS;
            end
        end
        i_word = q[WORD_W-1:0] & mask;
        if (i_cfg.swap_bytes) begin
            if (i_cfg.sample_bits == BITS_16) begin
                i_word = swap16(i_word);
            end else if (i_cfg.sample_bits == BITS_32) begin
                i_word = swap32(i_word);
            end
        end
    end

    // format selection and error codes
    always_comb begin
        o_word    = '0;
        o_clipped = 1'b0;
        o_error   = ERR_NONE;
        if (i_cfg.float_format) begin
            if (i_cfg.sample_bits != BITS_32) begin
                o_error = ERR_FLOAT_WIDTH;
            end else begin
                o_word    = i_cfg.swap_bytes ? swap32(f_word) : f_word;
                o_clipped = f_clip;
            end
        end else if (!(i_cfg.sample_bits inside {BITS_8, BITS_16, BITS_32})) begin
            o_error = ERR_BAD_WIDTH;
        end else if (i_cfg.sample_bits == BITS_32 && !i_cfg.signed_format) begin
            o_error = ERR_UNSIGNED_32;
        end else begin
            o_word    = i_word;
            o_clipped = i_clip;
        end
    end

endmodule
